[sv/virtual_csr_file_trap_emulator_unit_assert.svh]
// Assertion macros used by the trap emulator unit.
`ifndef VIRTUAL_CSR_FILE_TRAP_EMULATOR_UNIT_ASSERT_SVH
`define VIRTUAL_CSR_FILE_TRAP_EMULATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define VCSR_ASSERT_IMP(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define VCSR_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

[sv/vcsr_pkg.sv]
`default_nettype none
package vcsr_pkg;

  localparam int CSR_COUNT = 35;
  localparam int CSR_W     = 64;
  localparam int IDX_W     = $clog2(CSR_COUNT);

  localparam logic [CSR_W-1:0] VENDOR_ID = 64'h0000_6373_6535_3336;

  localparam logic [IDX_W-1:0] IDX_SSTATUS = 6'd0;
  localparam logic [IDX_W-1:0] IDX_STVEC   = 6'd2;
  localparam logic [IDX_W-1:0] IDX_SEPC    = 6'd5;
  localparam logic [IDX_W-1:0] IDX_VENDOR  = 6'd10;
  localparam logic [IDX_W-1:0] IDX_MSTATUS = 6'd15;
  localparam logic [IDX_W-1:0] IDX_MTVEC   = 6'd20;
  localparam logic [IDX_W-1:0] IDX_MEPC    = 6'd24;

  localparam logic [11:0] IMM_SRET = 12'h102;
  localparam logic [11:0] IMM_MRET = 12'h302;

  localparam logic [2:0] F3_PRIV = 3'd0;
  localparam logic [2:0] F3_CSRW = 3'd1;
  localparam logic [2:0] F3_CSRR = 3'd2;

  localparam logic [1:0] MODE_U = 2'd0;
  localparam logic [1:0] MODE_S = 2'd1;
  localparam logic [1:0] MODE_M = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } lookup_t;

  typedef struct packed {
    logic [2:0]       f3;
    logic [11:0]      imm;
    logic [4:0]       rd;
    logic [63:0]      src;
    logic [63:0]      pc;
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] addr_a;
    logic [IDX_W-1:0] addr_b;
  } item_t;

  typedef struct packed {
    logic [1:0]  mode_now;
    logic        killed;
    logic [63:0] read_value;
    logic [4:0]  dest_index;
    logic        dest_write;
    logic [63:0] next_pc;
  } result_t;

  function automatic lookup_t csr_lookup(input logic [11:0] addr);
    lookup_t r;
    r.hit = 1'b1;
    r.idx = '0;
    case (addr)
      12'h100: r.idx = 6'd0;
      12'h104: r.idx = 6'd1;
      12'h105: r.idx = 6'd2;
      12'h106: r.idx = 6'd3;
      12'h140: r.idx = 6'd4;
      12'h141: r.idx = 6'd5;
      12'h142: r.idx = 6'd6;
      12'h143: r.idx = 6'd7;
      12'h144: r.idx = 6'd8;
      12'h180: r.idx = 6'd9;
      12'hf11: r.idx = 6'd10;
      12'hf12: r.idx = 6'd11;
      12'hf13: r.idx = 6'd12;
      12'hf14: r.idx = 6'd13;
      12'hf15: r.idx = 6'd14;
      12'h300: r.idx = 6'd15;
      12'h301: r.idx = 6'd16;
      12'h302: r.idx = 6'd17;
      12'h303: r.idx = 6'd18;
      12'h304: r.idx = 6'd19;
      12'h305: r.idx = 6'd20;
      12'h306: r.idx = 6'd21;
      12'h310: r.idx = 6'd22;
      12'h340: r.idx = 6'd23;
      12'h341: r.idx = 6'd24;
      12'h342: r.idx = 6'd25;
      12'h343: r.idx = 6'd26;
      12'h344: r.idx = 6'd27;
      12'h34a: r.idx = 6'd28;
      12'h34b: r.idx = 6'd29;
      12'h3a0: r.idx = 6'd30;
      12'h3b0: r.idx = 6'd31;
      12'h3b1: r.idx = 6'd32;
      12'h3b2: r.idx = 6'd33;
      12'h3b3: r.idx = 6'd34;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] csr_min_mode(input logic [IDX_W-1:0] idx);
    logic [1:0] m;
    if (idx < 6'd10) begin
      m = MODE_S;
    end else if (idx < 6'd30) begin
      m = MODE_M;
    end else begin
      m = MODE_U;
    end
    return m;
  endfunction

  function automatic logic [CSR_W-1:0] csr_reset_value(input logic [IDX_W-1:0] idx);
    return (idx == IDX_VENDOR) ? VENDOR_ID : '0;
  endfunction

endpackage
`default_nettype wire

[sv/vcsr_ram.sv]
`default_nettype none
module vcsr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 35
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

[sv/virtual_csr_file_trap_emulator_unit.sv]
// Channel  Dir  Bits  Contents
// s_*      in   160   instruction, source_value, pc
// m_*      out  144   next_pc, dest_write, dest_index, read_value, killed, mode_now
//
// The accept cycle issues the CSR memory reads; the next cycle executes,
// writes back at most one entry and loads the output register.
// A new item is taken only while idle and the output register is empty or being drained.
// Reset and a kill clear all per-entry valid bits at once; an invalid entry
// reads as its reset value, so there is no clearing pass.
`default_nettype none
`include "virtual_csr_file_trap_emulator_unit_assert.svh"
module virtual_csr_file_trap_emulator_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // instruction[31:0], source_value[95:32], pc[159:96]
  input  logic [159:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // next_pc[63:0], dest_write[64], dest_index[69:65], read_value[133:70],
  // killed[134], mode_now[136:135], zero[143:137]
  output logic [143:0] m_tdata
);
  import vcsr_pkg::*;

  state_t           state, state_next;
  logic [1:0]       mode, mode_next;
  logic [CSR_COUNT-1:0] valid, valid_next;
  item_t            item, item_in;
  result_t          out_q, res;
  logic             accept;
  lookup_t          lk;
  logic [31:0]      instr;

  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [CSR_W-1:0] wdata;
  logic [CSR_W-1:0] rdata_a, rdata_b, val_a, val_b, stat;
  logic             mode_ok, kill;

  assign instr    = s_tdata[31:0];
  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign lk       = csr_lookup(instr[31:20]);

  always_comb begin
    item_in.f3     = instr[14:12];
    item_in.imm    = instr[31:20];
    item_in.rd     = instr[11:7];
    item_in.src    = s_tdata[95:32];
    item_in.pc     = s_tdata[159:96];
    item_in.hit    = lk.hit;
    item_in.idx    = lk.idx;
    item_in.addr_a = lk.idx;
    item_in.addr_b = (instr[31:20] == IMM_SRET) ? IDX_SEPC : IDX_MEPC;
    if (instr[14:12] == F3_PRIV) begin
      if (instr[31:20] == IMM_SRET) begin
        item_in.addr_a = IDX_SSTATUS;
      end else if (instr[31:20] == IMM_MRET) begin
        item_in.addr_a = IDX_MSTATUS;
      end else begin
        item_in.addr_a = (mode == MODE_U) ? IDX_STVEC : IDX_MTVEC;
      end
    end
  end

  vcsr_ram #(
    .WIDTH(CSR_W),
    .DEPTH(CSR_COUNT)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr_a(item_in.addr_a),
    .rdata_a(rdata_a),
    .raddr_b(item_in.addr_b),
    .rdata_b(rdata_b)
  );

  assign val_a   = valid[item.addr_a] ? rdata_a : csr_reset_value(item.addr_a);
  assign val_b   = valid[item.addr_b] ? rdata_b : csr_reset_value(item.addr_b);
  assign mode_ok = item.hit && (csr_min_mode(item.idx) <= mode);

  always_comb begin
    we             = 1'b0;
    waddr          = item.idx;
    wdata          = item.src;
    kill           = 1'b0;
    mode_next      = mode;
    stat           = val_a;
    res.next_pc    = item.pc;
    res.dest_write = 1'b0;
    res.dest_index = 5'd0;
    res.read_value = '0;
    case (item.f3)
      F3_CSRW: begin
        res.next_pc = item.pc + 64'd4;
        if (mode_ok) begin
          we = 1'b1;
        end else begin
          kill = 1'b1;
        end
      end
      F3_CSRR: begin
        res.next_pc    = item.pc + 64'd4;
        res.dest_index = item.rd;
        if (mode_ok) begin
          res.read_value = val_a;
          res.dest_write = (item.rd != 5'd0);
        end else begin
          kill = 1'b1;
        end
      end
      F3_PRIV: begin
        if (item.imm == IMM_SRET) begin
          if (mode == MODE_S) begin
            stat[1]     = val_a[1] | val_a[5];
            stat[5]     = 1'b1;
            mode_next   = val_a[8] ? MODE_S : MODE_U;
            we          = 1'b1;
            waddr       = IDX_SSTATUS;
            wdata       = stat;
            res.next_pc = val_b;
          end else begin
            kill = 1'b1;
          end
        end else if (item.imm == IMM_MRET) begin
          if (mode[1]) begin
            stat[3]     = val_a[3] | val_a[7];
            stat[7]     = 1'b1;
            if (val_a[12:11] < MODE_M) begin
              mode_next = val_a[12:11];
            end
            we          = 1'b1;
            waddr       = IDX_MSTATUS;
            wdata       = stat;
            res.next_pc = val_b;
          end else begin
            kill = 1'b1;
          end
        end else begin
          if (mode == MODE_U) begin
            we          = 1'b1;
            waddr       = IDX_SEPC;
            wdata       = item.pc;
            mode_next   = MODE_S;
            res.next_pc = val_a;
          end else if (mode == MODE_S) begin
            we          = 1'b1;
            waddr       = IDX_MEPC;
            wdata       = item.pc;
            mode_next   = MODE_M;
            res.next_pc = val_a;
          end else begin
            kill = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    if (kill) begin
      we        = 1'b0;
      mode_next = MODE_M;
    end
    if (state != S_EXEC) begin
      we        = 1'b0;
      mode_next = mode;
    end
    res.killed   = kill;
    res.mode_now = mode_next;
  end

  always_comb begin
    valid_next = valid;
    if (we) begin
      valid_next[waddr] = 1'b1;
    end
    if (state == S_EXEC && kill) begin
      valid_next = '0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_EXEC;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      mode     <= MODE_M;
      valid    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      valid <= valid_next;
      if (state == S_EXEC) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_in;
    end
    if (state == S_EXEC) begin
      out_q <= res;
    end
  end

  assign m_tdata = {7'd0, out_q};

  `VCSR_ASSERT_NEXT(a_accept_exec, clk, rst, accept, state == S_EXEC, "accept did not start execution")
  `VCSR_ASSERT_NEXT(a_exec_output, clk, rst, state == S_EXEC, m_tvalid, "execution did not load output")
  `VCSR_ASSERT_NEXT(a_kill_clears, clk, rst, state == S_EXEC && kill, valid == '0 && mode == MODE_M, "kill did not clear state")
  `VCSR_ASSERT_IMP(a_kill_mode, clk, rst, m_tvalid && out_q.killed, out_q.mode_now == MODE_M, "killed item reports wrong mode")
  `VCSR_ASSERT_IMP(a_mode_legal, clk, rst, 1'b1, mode != 2'd3, "privilege mode out of range")

endmodule
`default_nettype wire

[tb/virtual_csr_file_trap_emulator_unit_tb.sv]
`timescale 1ns / 100ps
module virtual_csr_file_trap_emulator_unit_tb;
  import vcsr_pkg::*;

  localparam int LIMIT = 500000;
  localparam int RANDOM_ITEMS = 1050;
  localparam int USER_FIRST = 30;

  localparam logic [11:0] CSR_ADDRS [CSR_COUNT] = '{
    12'h100, 12'h104, 12'h105, 12'h106,
    12'h140, 12'h141, 12'h142, 12'h143, 12'h144,
    12'h180,
    12'hf11, 12'hf12, 12'hf13, 12'hf14, 12'hf15,
    12'h300, 12'h301, 12'h302, 12'h303, 12'h304, 12'h305, 12'h306, 12'h310,
    12'h340, 12'h341, 12'h342, 12'h343, 12'h344, 12'h34a, 12'h34b,
    12'h3a0, 12'h3b0, 12'h3b1, 12'h3b2, 12'h3b3
  };

  class trap_result_board;
    result_t pending[$];
    logic [63:0] csr_file [CSR_COUNT];
    logic [1:0] mode;
    int errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      foreach (csr_file[i]) csr_file[i] = (i == IDX_VENDOR) ? VENDOR_ID : 64'd0;
      mode = MODE_M;
    endfunction

    function int slot_of(logic [11:0] addr);
      for (int i = 0; i < CSR_COUNT; i++) begin
        if (CSR_ADDRS[i] == addr) return i;
      end
      return -1;
    endfunction

    function logic [1:0] floor_mode(int slot);
      if (slot < 10) return MODE_S;
      if (slot < USER_FIRST) return MODE_M;
      return MODE_U;
    endfunction

    function void note_item(logic [31:0] ins, logic [63:0] src, logic [63:0] pc);
      result_t r;
      int k;
      logic kill;
      logic [2:0] f3;
      logic [11:0] imm;
      logic [4:0] rd;
      logic [63:0] st;
      r = '0;
      r.next_pc = pc;
      kill = 1'b0;
      f3 = ins[14:12];
      imm = ins[31:20];
      rd = ins[11:7];
      case (f3)
        F3_CSRW: begin
          k = slot_of(imm);
          if (k >= 0 && floor_mode(k) <= mode) csr_file[k] = src;
          else kill = 1'b1;
          r.next_pc = pc + 64'd4;
        end
        F3_CSRR: begin
          k = slot_of(imm);
          r.dest_index = rd;
          if (k >= 0 && floor_mode(k) <= mode) begin
            r.read_value = csr_file[k];
            r.dest_write = (rd != 5'd0);
          end else begin
            kill = 1'b1;
          end
          r.next_pc = pc + 64'd4;
        end
        F3_PRIV: begin
          if (imm == IMM_SRET) begin
            if (mode == MODE_S) begin
              st = csr_file[IDX_SSTATUS];
              st[1] = st[1] | st[5];
              st[5] = 1'b1;
              if (!st[8]) mode = MODE_U;
              csr_file[IDX_SSTATUS] = st;
              r.next_pc = csr_file[IDX_SEPC];
            end else begin
              kill = 1'b1;
            end
          end else if (imm == IMM_MRET) begin
            if (mode >= MODE_M) begin
              st = csr_file[IDX_MSTATUS];
              st[3] = st[3] | st[7];
              st[7] = 1'b1;
              if (st[12:11] < MODE_M) mode = st[12:11];
              csr_file[IDX_MSTATUS] = st;
              r.next_pc = csr_file[IDX_MEPC];
            end else begin
              kill = 1'b1;
            end
          end else if (mode == MODE_U) begin
            csr_file[IDX_SEPC] = pc;
            mode = MODE_S;
            r.next_pc = csr_file[IDX_STVEC];
          end else if (mode == MODE_S) begin
            csr_file[IDX_MEPC] = pc;
            mode = MODE_M;
            r.next_pc = csr_file[IDX_MTVEC];
          end else begin
            kill = 1'b1;
          end
        end
        default: ;
      endcase
      if (kill) clear();
      r.killed = kill;
      r.mode_now = mode;
      pending.push_back(r);
    endfunction

    function void check_result(logic [143:0] word);
      result_t got;
      result_t want;
      got = word[136:0];
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: next_pc=%h", got.next_pc);
        return;
      end
      want = pending.pop_front();
      if (got !== want || word[143:137] !== 7'd0) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch exp: pc=%h wr=%b rd=%0d val=%h kill=%b mode=%0d",
                   want.next_pc, want.dest_write, want.dest_index, want.read_value,
                   want.killed, want.mode_now);
          $display("         got: pc=%h wr=%b rd=%0d val=%h kill=%b mode=%0d pad=%h",
                   got.next_pc, got.dest_write, got.dest_index, got.read_value,
                   got.killed, got.mode_now, word[143:137]);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [159:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [143:0] m_tdata;

  trap_result_board board = new();
  int burst_left = 4;
  int cycle_count = 0;

  virtual_csr_file_trap_emulator_unit dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  initial begin
    int style;
    int run;
    m_tready <= 1'b0;
    forever begin
      style = $urandom_range(0, 3);
      run = $urandom_range(8, 64);
      repeat (run) begin
        @(posedge clk);
        case (style)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ~m_tready;
        endcase
      end
    end
  end

  function automatic logic [31:0] encode(logic [2:0] f3, logic [11:0] imm, logic [4:0] rd,
                                         logic [4:0] rs1);
    return {imm, rs1, f3, rd, 7'h73};
  endfunction

  task automatic send_item(input logic [31:0] ins, input logic [63:0] src,
                           input logic [63:0] pc);
    s_tvalid <= 1'b1;
    s_tdata <= {pc, src, ins};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_item(ins, src, pc);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 20);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_random();
    logic [31:0] ins;
    logic [63:0] src;
    logic [63:0] pc;
    logic [2:0] f3;
    logic [11:0] imm;
    logic [4:0] rd;
    int op;
    int k;
    op = $urandom_range(0, 99);
    rd = ($urandom_range(0, 7) == 0) ? 5'd0 : 5'($urandom);
    src = {$urandom, $urandom};
    pc = {$urandom, $urandom};
    imm = 12'($urandom);
    f3 = F3_PRIV;
    if (op < 60) begin
      f3 = (op < 32) ? F3_CSRW : F3_CSRR;
      if ($urandom_range(0, 9) != 0) begin
        k = $urandom_range(0, CSR_COUNT - 1);
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 5))
            0: k = IDX_SSTATUS;
            1: k = IDX_MSTATUS;
            2: k = IDX_SEPC;
            3: k = IDX_MEPC;
            4: k = IDX_STVEC;
            default: k = IDX_MTVEC;
          endcase
        end
        if ($urandom_range(0, 9) != 0) begin
          while (board.floor_mode(k) > board.mode) k = $urandom_range(0, CSR_COUNT - 1);
        end
        imm = CSR_ADDRS[k];
      end
    end else if (op < 72) begin
      if ($urandom_range(0, 1) == 0) imm = 12'h000;
    end else if (op < 92) begin
      if (board.mode == MODE_M) imm = ($urandom_range(0, 6) == 0) ? IMM_SRET : IMM_MRET;
      else if (board.mode == MODE_S) imm = ($urandom_range(0, 6) == 0) ? IMM_MRET : IMM_SRET;
      else imm = ($urandom_range(0, 1) == 0) ? IMM_MRET : IMM_SRET;
    end else begin
      f3 = 3'($urandom_range(3, 7));
    end
    ins = encode(f3, imm, rd, 5'($urandom));
    ins[6:0] = 7'($urandom);
    if (op >= 96) ins = $urandom;
    send_item(ins, src, pc);
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_item(encode(F3_CSRR, CSR_ADDRS[IDX_VENDOR], 5'd31, 5'd0), '0, '0);
    send_item(encode(F3_CSRR, CSR_ADDRS[IDX_MSTATUS], 5'd0, 5'd31), '1, 64'h10);
    send_item(encode(F3_CSRW, CSR_ADDRS[IDX_MTVEC], 5'd3, 5'd4), '1, 64'hFFFF_FFFF_FFFF_FFFC);
    send_item(encode(F3_CSRW, CSR_ADDRS[IDX_MEPC], 5'd0, 5'd5), 64'h8000_1000, 64'h20);
    send_item(encode(F3_CSRW, CSR_ADDRS[IDX_MSTATUS], 5'd0, 5'd6), 64'h80, 64'h24);
    send_item(encode(F3_PRIV, IMM_MRET, 5'd0, 5'd0), '0, 64'h28);
    send_item(encode(F3_CSRR, CSR_ADDRS[USER_FIRST], 5'd5, 5'd0), '0, 64'h8000_1000);
    send_item(encode(F3_CSRW, CSR_ADDRS[CSR_COUNT - 1], 5'd0, 5'd31), '1, 64'h8000_1004);
    send_item(encode(F3_PRIV, 12'h000, 5'd0, 5'd0), '0, 64'h1234);
    send_item(encode(F3_CSRW, CSR_ADDRS[IDX_STVEC], 5'd0, 5'd1), 64'h4000, 64'h0);
    send_item(encode(F3_CSRW, CSR_ADDRS[IDX_SSTATUS], 5'd0, 5'd2), 64'h120, 64'h4);
    send_item(encode(F3_PRIV, IMM_SRET, 5'd0, 5'd0), '0, 64'h8);
    send_item(encode(F3_CSRW, CSR_ADDRS[IDX_SSTATUS], 5'd0, 5'd2), 64'h20, 64'h1238);
    send_item(encode(F3_PRIV, IMM_SRET, 5'd0, 5'd0), '0, 64'h123c);
    send_item(encode(F3_PRIV, IMM_SRET, 5'd0, 5'd0), '0, 64'h100);
    send_item(encode(F3_PRIV, 12'h001, 5'd0, 5'd0), '0, 64'h104);
    send_item(encode(F3_CSRW, CSR_ADDRS[IDX_MSTATUS], 5'd0, 5'd7), 64'h800, 64'h108);
    send_item(encode(F3_PRIV, IMM_MRET, 5'd0, 5'd0), '0, 64'h10c);
    send_item(encode(F3_PRIV, IMM_MRET, 5'd0, 5'd0), '0, 64'h110);
    send_item(encode(F3_PRIV, IMM_MRET, 5'd0, 5'd0), '0, 64'h114);
    send_item(encode(F3_PRIV, 12'h000, 5'd0, 5'd0), '0, 64'h118);
    send_item(encode(F3_PRIV, 12'h000, 5'd0, 5'd0), '0, 64'h11c);
    send_item(encode(F3_PRIV, IMM_MRET, 5'd0, 5'd0), '0, 64'h120);
    send_item(encode(F3_PRIV, 12'h000, 5'd0, 5'd0), '0, 64'h124);
    send_item(encode(F3_CSRR, CSR_ADDRS[IDX_MSTATUS], 5'd9, 5'd0), '0, 64'h128);
    send_item(encode(F3_CSRW, CSR_ADDRS[IDX_MSTATUS], 5'd0, 5'd8), 64'h1800, 64'h12c);
    send_item(encode(F3_PRIV, IMM_MRET, 5'd0, 5'd0), '0, 64'h130);
    send_item(encode(F3_CSRR, 12'h7ff, 5'd1, 5'd0), '0, 64'h134);
    send_item(encode(F3_CSRW, 12'hfff, 5'd0, 5'd0), '0, 64'h138);
    send_item('1, '1, '1);

    repeat (RANDOM_ITEMS) send_random();
    s_tvalid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
